/* rtl/cached_lock_grant_revoke_table_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the lock grant and revoke table
// Concurrent check macros; they expand to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef CACHED_LOCK_GRANT_REVOKE_TABLE_DEFINES_SVH
`define CACHED_LOCK_GRANT_REVOKE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define CLGRT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define CLGRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CLGRT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CLGRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/clgrt_pkg.sv */
// ---------------------------------------------------------------------------
// Lock table package
// Sizes, codes and transaction types shared by the lock table modules.
// ---------------------------------------------------------------------------
package clgrt_pkg;

  localparam int LOCK_COUNT   = 64;
  localparam int CLIENT_COUNT = 16;
  localparam int WAIT_DEPTH   = 16;

  localparam int LOCK_W   = 6;
  localparam int CLIENT_W = 4;
  localparam int HEAD_W   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CNT_W    = HEAD_W + 1;
  localparam int SLOT_AW  = LOCK_W + HEAD_W;

  typedef enum logic {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    PH_FREE     = 2'd0,
    PH_GRANTED  = 2'd1,
    PH_REVOKING = 2'd2,
    PH_GRANTING = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RETRY    = 2'd1,
    ST_NOTOWNER = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    NT_NONE   = 2'd0,
    NT_REVOKE = 2'd1,
    NT_RETRY  = 2'd2
  } notify_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [LOCK_W-1:0]   lock_id;
    logic [CLIENT_W-1:0] client_id;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    notify_t             notify_kind;
    logic [CLIENT_W-1:0] notify_client;
    logic                more_waiting;
  } out_item_t;

  typedef struct packed {
    phase_t              phase;
    logic [CLIENT_W-1:0] owner;
    logic [HEAD_W-1:0]   head;
    logic [CNT_W-1:0]    count;
  } lock_entry_t;

  localparam lock_entry_t ENTRY_RESET = '{
    phase: PH_FREE, owner: '0, head: '0, count: '0
  };

endpackage

/* rtl/clgrt_lock_tbl.sv */
// ---------------------------------------------------------------------------
// Lock entry table
// Synchronous memory of lock entries with a registered read; entries never written since
// reset read back as a free lock with an empty wait queue.
// ---------------------------------------------------------------------------
module clgrt_lock_tbl
  import clgrt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [LOCK_W-1:0] rd_addr,
  output lock_entry_t       rd_data,
  input  logic              wr_en,
  input  logic [LOCK_W-1:0] wr_addr,
  input  lock_entry_t       wr_data
);

  lock_entry_t           mem [LOCK_COUNT];
  logic [LOCK_COUNT-1:0] valid_r;
  lock_entry_t           rd_data_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : ENTRY_RESET;

endmodule

/* rtl/cached_lock_grant_revoke_table.sv */
// Result: the result strobe is registered and rises after the S_LOOK state, or after the
// S_FETCH state for a release that hands the lock to a waiter.
// Busy: a new transaction is taken only once the lock entry memory has been read and
// written back; a release that hands the lock to a waiter also waits for the wait slot
// memory read.
// Reset: synchronous, active low; all locks read as free with empty queues at once.
// ---------------------------------------------------------------------------
// Cached lock grant and revoke table
// Lock manager with per-lock owner, phase and a FIFO of waiting clients.
// ---------------------------------------------------------------------------
`include "cached_lock_grant_revoke_table_defines.svh"

module cached_lock_grant_revoke_table
  import clgrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_req,
  output logic      out_valid,
  output out_item_t out_result
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_LOOK  = 3'b010,
    S_FETCH = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  in_item_t    req_r;
  lock_entry_t ent_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_result_r, out_result_nxt;

  logic        accept;
  lock_entry_t ent;
  logic        tbl_we;
  lock_entry_t tbl_wdata;
  logic        slot_we;
  logic        slot_re;
  logic [HEAD_W-1:0] slot_widx;
  logic [CLIENT_W-1:0] slot_q;
  logic [CLIENT_W-1:0] slot_mem [1 << SLOT_AW];

  logic              range_ok;
  logic [HEAD_W:0]   tail_sum;
  logic [HEAD_W-1:0] tail_idx;
  logic [HEAD_W:0]   head_sum;
  logic [HEAD_W-1:0] head_idx;
  logic [CNT_W-1:0]  left;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  clgrt_lock_tbl u_lock_tbl (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_req.lock_id),
    .rd_data (ent),
    .wr_en   (tbl_we),
    .wr_addr (req_r.lock_id),
    .wr_data (tbl_wdata)
  );

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[{req_r.lock_id, slot_widx}] <= req_r.client_id;
    end
    if (slot_re) begin
      slot_q <= slot_mem[{req_r.lock_id, ent.head}];
    end
  end

  assign range_ok = ({1'b0, req_r.lock_id} < (LOCK_W + 1)'(LOCK_COUNT)) &&
                    ({1'b0, req_r.client_id} < (CLIENT_W + 1)'(CLIENT_COUNT));

  assign tail_sum  = {1'b0, ent.head} + ent.count[HEAD_W:0];
  assign tail_idx  = (tail_sum >= (HEAD_W + 1)'(WAIT_DEPTH)) ?
                     HEAD_W'(tail_sum - (HEAD_W + 1)'(WAIT_DEPTH)) : tail_sum[HEAD_W-1:0];
  assign head_sum  = {1'b0, ent_r.head} + (HEAD_W + 1)'(1);
  assign head_idx  = (head_sum >= (HEAD_W + 1)'(WAIT_DEPTH)) ?
                     HEAD_W'(head_sum - (HEAD_W + 1)'(WAIT_DEPTH)) : head_sum[HEAD_W-1:0];
  assign left      = ent_r.count - CNT_W'(1);
  assign slot_widx = tail_idx;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = '{status: ST_OK, notify_kind: NT_NONE, notify_client: '0,
                       more_waiting: 1'b0};
    tbl_we         = 1'b0;
    tbl_wdata      = ent;
    slot_we        = 1'b0;
    slot_re        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (!range_ok) begin
          out_result_nxt.status = ST_NOTOWNER;
        end else begin
          case (req_r.cmd)
            CMD_ACQUIRE: begin
              if (ent.phase == PH_FREE) begin
                tbl_we          = 1'b1;
                tbl_wdata.phase = PH_GRANTED;
                tbl_wdata.owner = req_r.client_id;
              end else if (ent.count >= CNT_W'(WAIT_DEPTH)) begin
                out_result_nxt.status = ST_FULL;
              end else begin
                slot_we               = 1'b1;
                tbl_we                = 1'b1;
                tbl_wdata.count       = ent.count + CNT_W'(1);
                out_result_nxt.status = ST_RETRY;
                if (ent.phase == PH_GRANTED) begin
                  tbl_wdata.phase              = PH_REVOKING;
                  out_result_nxt.notify_kind   = NT_REVOKE;
                  out_result_nxt.notify_client = ent.owner;
                end
              end
            end
            CMD_RELEASE: begin
              if (ent.phase == PH_FREE || ent.owner != req_r.client_id) begin
                out_result_nxt.status = ST_NOTOWNER;
              end else if (ent.count == '0) begin
                tbl_we          = 1'b1;
                tbl_wdata.phase = PH_FREE;
                tbl_wdata.owner = '0;
              end else begin
                slot_re       = 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = S_FETCH;
              end
            end
            default: begin
              out_result_nxt.status = ST_NOTOWNER;
            end
          endcase
        end
      end
      S_FETCH: begin
        state_nxt       = S_IDLE;
        out_valid_nxt   = 1'b1;
        tbl_we          = 1'b1;
        tbl_wdata       = ent_r;
        tbl_wdata.owner = slot_q;
        tbl_wdata.head  = head_idx;
        tbl_wdata.count = left;
        tbl_wdata.phase = (left != '0) ? PH_GRANTING : PH_GRANTED;
        out_result_nxt.notify_kind   = NT_RETRY;
        out_result_nxt.notify_client = slot_q;
        out_result_nxt.more_waiting  = (left != '0);
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    if (state_r == S_LOOK) begin
      ent_r <= ent;
    end
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  `CLGRT_ASSERT_NEXT(a_accept_look, clk, rst_n, accept, state_r == S_LOOK)
  `CLGRT_ASSERT_SAME(a_out_source, clk, rst_n, out_valid_r, $past(state_r) == S_LOOK || $past(state_r) == S_FETCH)
  `CLGRT_ASSERT_SAME(a_fetch_release, clk, rst_n, state_r == S_FETCH, $past(state_r) == S_LOOK && req_r.cmd == CMD_RELEASE)
  `CLGRT_ASSERT_SAME(a_more_grant, clk, rst_n, out_valid_r && out_result_r.more_waiting, out_result_r.notify_kind == NT_RETRY)

endmodule
